// File: rtl/cadw_pkg.sv
// ----------------------------------------------------------------------------
// Calendar add-days package
// Field widths, item layouts and the small arithmetic helpers that the
// date pipeline shares between its stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cadw_pkg;

	localparam int YEAR_W       = 14;
	localparam int MONTH_W      = 4;
	localparam int DAY_W        = 5;
	localparam int WDAY_W       = 3;
	localparam int DNUM_W       = 23;
	localparam int OFFSET_WIDTH = 21;

	// Every day number the pipeline can reach fits in 24 unsigned bits.
	localparam int JDN_W  = 24;
	localparam int JSUM_W = 27;

	localparam int IN_BITS     = YEAR_W + MONTH_W + DAY_W + OFFSET_WIDTH;
	localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS    = YEAR_W + MONTH_W + DAY_W + WDAY_W + DNUM_W;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	localparam int YEAR_MIN = 1583;
	localparam int YEAR_MAX = 9999;
	localparam int GREG_JDN = 2299161;

	localparam logic [WDAY_W-1:0] WD_SUNDAY   = 3'd0;
	localparam logic [WDAY_W-1:0] WD_MONDAY   = 3'd1;
	localparam logic [WDAY_W-1:0] WD_SATURDAY = 3'd6;

	typedef struct packed {
		logic [OFFSET_WIDTH-1:0] day_offset;
		logic [DAY_W-1:0]        in_day;
		logic [MONTH_W-1:0]      in_month;
		logic [YEAR_W-1:0]       in_year;
	} in_item_t;

	typedef struct packed {
		logic [JDN_W-1:0]  jdn;
		logic [WDAY_W-1:0] weekday;
	} roll_item_t;

	typedef struct packed {
		logic [DNUM_W-1:0]  day_number;
		logic [WDAY_W-1:0]  out_weekday;
		logic [DAY_W-1:0]   out_day;
		logic [MONTH_W-1:0] out_month;
		logic [YEAR_W-1:0]  out_year;
	} out_data_t;

	typedef struct packed {
		logic      range_error;
		out_data_t data;
	} res_t;

	// floor(30.6001 * k) for k from 0 to 16.
	function automatic logic [8:0] f306(input logic [4:0] k);
		logic [8:0] r;
		case (k)
			5'd1:    r = 9'd30;
			5'd2:    r = 9'd61;
			5'd3:    r = 9'd91;
			5'd4:    r = 9'd122;
			5'd5:    r = 9'd153;
			5'd6:    r = 9'd183;
			5'd7:    r = 9'd214;
			5'd8:    r = 9'd244;
			5'd9:    r = 9'd275;
			5'd10:   r = 9'd306;
			5'd11:   r = 9'd336;
			5'd12:   r = 9'd367;
			5'd13:   r = 9'd397;
			5'd14:   r = 9'd428;
			5'd15:   r = 9'd459;
			5'd16:   r = 9'd489;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	// Remainder by seven: eight equals one modulo seven, so the octal digits are summed.
	function automatic logic [2:0] mod7(input logic [JDN_W:0] x);
		logic [26:0] xp;
		logic [5:0]  s1;
		logic [3:0]  s2;
		logic [3:0]  s3;
		xp = {{(26 - JDN_W){1'b0}}, x};
		s1 = '0;
		for (int i = 0; i < 9; i++) begin
			s1 = s1 + {3'b000, xp[3*i +: 3]};
		end
		s2 = {1'b0, s1[5:3]} + {1'b0, s1[2:0]};
		s3 = {3'b000, s2[3]} + {1'b0, s2[2:0]};
		if (s3 == 4'd7) begin
			s3 = 4'd0;
		end
		return s3[2:0];
	endfunction

endpackage

`default_nettype wire

// File: rtl/cadw_fwd.sv
// ----------------------------------------------------------------------------
// Date to day number
// Two stages: year and century terms by constant products, month term by table,
// then all terms and the signed offset are summed into a day number.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cadw_fwd import cadw_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_item_t         in_item,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [JDN_W-1:0] out_jdn
);

	logic        en_s1, en_s2;
	logic        valid_s1, valid_s2;

	logic        early;
	logic [14:0] yy;
	logic [27:0] cent_prod;
	logic [14:0] ty;
	logic [25:0] year_prod;
	logic [3:0]  madj;

	logic [23:0]             tyear_s1;
	logic [8:0]              tmon_s1;
	logic [7:0]              cent_s1;
	logic [DAY_W-1:0]        day_s1;
	logic [OFFSET_WIDTH-1:0] off_s1;

	logic signed [9:0]        a_c;
	logic signed [9:0]        b_c;
	logic signed [JSUM_W-1:0] jsum;
	logic [JDN_W-1:0]         jdn_s2;

	assign en_s2    = !valid_s2 || out_ready;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_ready = en_s1;

	always_comb begin
		early     = (in_item.in_month <= 4'd2);
		yy        = {1'b0, in_item.in_year} + 15'd100 - {14'd0, early};
		cent_prod = {13'd0, yy} * 28'd5243;
		ty        = {1'b0, in_item.in_year} + 15'd4716 - {14'd0, early};
		year_prod = {11'd0, ty} * 26'd1461;
		madj      = early ? in_item.in_month + 4'd12 : in_item.in_month;
	end

	always_comb begin
		a_c  = $signed({2'b00, cent_s1}) - 10'sd1;
		b_c  = 10'sd2 - a_c + (a_c >>> 2);
		jsum = $signed({3'b000, tyear_s1})
			+ $signed({18'd0, tmon_s1})
			+ $signed({22'd0, day_s1})
			+ $signed({{(JSUM_W - 10){b_c[9]}}, b_c})
			+ $signed({{(JSUM_W - OFFSET_WIDTH){off_s1[OFFSET_WIDTH-1]}}, off_s1})
			- 27'sd1524;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= in_valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// The century count is floor(yy / 100) with yy biased by one century.
	always_ff @(posedge clk) begin
		if (en_s1) begin
			tyear_s1 <= year_prod[25:2];
			tmon_s1  <= f306({1'b0, madj} + 5'd1);
			cent_s1  <= cent_prod[26:19];
			day_s1   <= in_item.in_day;
			off_s1   <= in_item.day_offset;
		end
		if (en_s2) begin
			jdn_s2 <= jsum[JDN_W-1:0];
		end
	end

	assign out_valid = valid_s2;
	assign out_jdn   = jdn_s2;

endmodule

`default_nettype wire

// File: rtl/cadw_roll.sv
// ----------------------------------------------------------------------------
// Weekday and weekend roll
// One stage: finds the weekday of the day number and, when rolling is
// enabled, moves a Saturday or Sunday to the following Monday.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cadw_roll import cadw_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             weekend_roll,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [JDN_W-1:0] in_jdn,
	output logic             out_valid,
	input  logic             out_ready,
	output roll_item_t       out_item
);

	logic              en_s1;
	logic              valid_s1;
	logic [WDAY_W-1:0] wd_raw;
	roll_item_t        rolled;
	roll_item_t        item_s1;

	assign en_s1    = !valid_s1 || out_ready;
	assign in_ready = en_s1;

	always_comb begin
		wd_raw         = mod7({1'b0, in_jdn} + {{JDN_W{1'b0}}, 1'b1});
		rolled.jdn     = in_jdn;
		rolled.weekday = wd_raw;
		if (weekend_roll && wd_raw == WD_SATURDAY) begin
			rolled.jdn     = in_jdn + 24'd2;
			rolled.weekday = WD_MONDAY;
		end else if (weekend_roll && wd_raw == WD_SUNDAY) begin
			rolled.jdn     = in_jdn + 24'd1;
			rolled.weekday = WD_MONDAY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			item_s1 <= rolled;
		end
	end

	assign out_valid = valid_s1;
	assign out_item  = item_s1;

endmodule

`default_nettype wire

// File: rtl/cadw_inv.sv
// ----------------------------------------------------------------------------
// Day number to date
// Seven stages: Gregorian century correction, year count and month search.
// Each constant division is a reciprocal product followed by one
// remainder check in the next stage. The last stage is the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cadw_inv import cadw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  roll_item_t in_item,
	output logic       out_valid,
	input  logic       out_ready,
	output res_t       out_res
);

	localparam int NS       = 7;
	localparam int DIV_CENT = 146097;
	localparam int RCP_CENT = 29398;
	localparam int DIV_YEAR = 7305;
	localparam int RCP_YEAR = 587948;

	logic [NS:1] valid_q;
	logic [NS:1] en;

	// Stage 1: century quotient estimate.
	logic [25:0] n1_full;
	logic [39:0] q0_prod;
	roll_item_t  item_s1;
	logic        greg_s1;
	logic [24:0] n1_s1;
	logic [7:0]  q0_s1;

	// Stage 2: century quotient corrected.
	logic [25:0] r1;
	logic [7:0]  x_c;
	roll_item_t  item_s2;
	logic        greg_s2;
	logic [7:0]  x_s2;

	// Stage 3: shifted day count and year numerator.
	logic [24:0] a_c;
	logic [24:0] b_c;
	logic [27:0] n2_c;
	roll_item_t  item_s3;
	logic [23:0] b_s3;
	logic [27:0] n2_s3;

	// Stage 4: year quotient estimate.
	logic [47:0] qc_prod;
	roll_item_t  item_s4;
	logic [23:0] b_s4;
	logic [27:0] n2_s4;
	logic [15:0] qc_s4;

	// Stage 5: year quotient corrected.
	logic [28:0] r2;
	logic [15:0] c_c;
	roll_item_t  item_s5;
	logic [23:0] b_s5;
	logic [14:0] c_s5;

	// Stage 6: day of the shifted year.
	logic [25:0] dd_prod;
	logic [23:0] vdiff;
	roll_item_t  item_s6;
	logic [14:0] c_s6;
	logic [9:0]  v_s6;

	// Stage 7: month search and output.
	logic [4:0]         e_c;
	logic [9:0]         rd_c;
	logic [4:0]         rm_c;
	logic signed [16:0] ry_c;
	res_t               res_c;
	res_t               res_s7;

	always_comb begin
		en[NS] = !valid_q[NS] || out_ready;
		for (int k = NS - 1; k >= 1; k--) begin
			en[k] = !valid_q[k] || en[k+1];
		end
	end

	assign in_ready = en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (en[1]) begin
				valid_q[1] <= in_valid;
			end
			for (int k = 2; k <= NS; k++) begin
				if (en[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

	always_comb begin
		n1_full = {in_item.jdn, 2'b00} - 26'd7468865;
		q0_prod = {15'd0, n1_full[24:0]} * 40'(RCP_CENT);
	end

	always_comb begin
		r1  = {1'b0, n1_s1} - {18'd0, q0_s1} * 26'(DIV_CENT);
		x_c = q0_s1 + {7'd0, (r1 >= 26'(DIV_CENT))};
	end

	always_comb begin
		if (greg_s2) begin
			a_c = {1'b0, item_s2.jdn} + 25'd1 + {17'd0, x_s2} - {19'd0, x_s2[7:2]};
		end else begin
			a_c = {1'b0, item_s2.jdn};
		end
		b_c  = a_c + 25'd1524;
		n2_c = {b_c[23:0], 4'b0000} + {2'b00, b_c[23:0], 2'b00} - 28'd2442;
	end

	always_comb begin
		qc_prod = {20'd0, n2_s3} * 48'(RCP_YEAR);
	end

	always_comb begin
		r2  = {1'b0, n2_s4} - {13'd0, qc_s4} * 29'(DIV_YEAR);
		c_c = qc_s4 + {15'd0, (r2 >= 29'(DIV_YEAR))};
	end

	always_comb begin
		dd_prod = {11'd0, c_s5} * 26'd1461;
		vdiff   = b_s5 - dd_prod[25:2];
	end

	// The month index is the largest k whose table entry lies below the day count.
	always_comb begin
		e_c = 5'd0;
		for (int k = 1; k <= 16; k++) begin
			if ({1'b0, f306(5'(k))} < v_s6) begin
				e_c = 5'(k);
			end
		end
		rd_c = v_s6 - {1'b0, f306(e_c)};
		rm_c = (e_c < 5'd14) ? e_c - 5'd1 : e_c - 5'd13;
		ry_c = $signed({2'b00, c_s6}) - ((rm_c > 5'd2) ? 17'sd4716 : 17'sd4715);
		res_c.data.out_year    = ry_c[YEAR_W-1:0];
		res_c.data.out_month   = rm_c[MONTH_W-1:0];
		res_c.data.out_day     = rd_c[DAY_W-1:0];
		res_c.data.out_weekday = item_s6.weekday;
		res_c.data.day_number  = item_s6.jdn[DNUM_W-1:0];
		res_c.range_error      = (ry_c < 17'sd1583) || (ry_c > 17'sd9999);
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			item_s1 <= in_item;
			greg_s1 <= (in_item.jdn >= 24'(GREG_JDN));
			n1_s1   <= n1_full[24:0];
			q0_s1   <= q0_prod[39:32];
		end
		if (en[2]) begin
			item_s2 <= item_s1;
			greg_s2 <= greg_s1;
			x_s2    <= x_c;
		end
		if (en[3]) begin
			item_s3 <= item_s2;
			b_s3    <= b_c[23:0];
			n2_s3   <= n2_c;
		end
		if (en[4]) begin
			item_s4 <= item_s3;
			b_s4    <= b_s3;
			n2_s4   <= n2_s3;
			qc_s4   <= qc_prod[47:32];
		end
		if (en[5]) begin
			item_s5 <= item_s4;
			b_s5    <= b_s4;
			c_s5    <= c_c[14:0];
		end
		if (en[6]) begin
			item_s6 <= item_s5;
			c_s6    <= c_s5;
			v_s6    <= vdiff[9:0];
		end
		if (en[7]) begin
			res_s7 <= res_c;
		end
	end

	assign out_valid = valid_q[NS];
	assign out_res   = res_s7;

endmodule

`default_nettype wire

// File: rtl/calendar_add_days_weekend_roll_core.sv
// ----------------------------------------------------------------------------
// Calendar add-days core with weekend roll
// An accepted item passes cadw_fwd, cadw_roll and cadw_inv in turn to reach m_axis_tvalid.
// Throughput: one item per cycle unless the output stalls; every stage has its
// own valid bit and the ready chain lets bubbles close up during output stalls.
// Reset clears all stage valid bits and weekend_roll at once; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module calendar_add_days_weekend_roll_core import cadw_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// in_year, in_month, in_day, day_offset
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// out_year, out_month, out_day, out_weekday, day_number
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	// range_error
	output logic                   m_axis_tuser,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic                   cfg_data
);

	logic             weekend_roll_q;
	in_item_t         in_item;
	logic             fwd_valid, fwd_ready;
	logic [JDN_W-1:0] fwd_jdn;
	logic             roll_valid, roll_ready;
	roll_item_t       roll_item;
	res_t             res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weekend_roll_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			weekend_roll_q <= cfg_data;
		end
	end

	assign in_item = s_axis_tdata[IN_BITS-1:0];

	cadw_fwd u_fwd (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_item   (in_item),
		.out_valid (fwd_valid),
		.out_ready (fwd_ready),
		.out_jdn   (fwd_jdn)
	);

	cadw_roll u_roll (
		.clk          (clk),
		.arst_n       (arst_n),
		.weekend_roll (weekend_roll_q),
		.in_valid     (fwd_valid),
		.in_ready     (fwd_ready),
		.in_jdn       (fwd_jdn),
		.out_valid    (roll_valid),
		.out_ready    (roll_ready),
		.out_item     (roll_item)
	);

	cadw_inv u_inv (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (roll_valid),
		.in_ready  (roll_ready),
		.in_item   (roll_item),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res)
	);

	assign m_axis_tdata = {{(OUT_TDATA_W - OUT_BITS){1'b0}}, res.data};
	assign m_axis_tuser = res.range_error;

endmodule

`default_nettype wire

// File: rtl/cadw_checker.sv
// ----------------------------------------------------------------------------
// Calendar add-days port checker
// Watches the ports of the core for weekday codes, range flag consistency,
// the Gregorian start, stall behavior and backpressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cadw_checker import cadw_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tready,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input logic                   m_axis_tuser
);

	out_data_t od;

	assign od = m_axis_tdata[OUT_BITS-1:0];

	a_weekday_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> od.out_weekday != 3'd7)
		else $error("weekday code out of range");

	a_range_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |->
			od.out_year >= 14'(YEAR_MIN) && od.out_year <= 14'(YEAR_MAX))
		else $error("year outside range without range flag");

	a_gregorian: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> od.day_number >= 23'(GREG_JDN))
		else $error("in-range result before the Gregorian start");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input refused while output is free");

endmodule

bind calendar_add_days_weekend_roll_core cadw_checker u_checker (.*);

`default_nettype wire

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// Calendar add-days core testbench
// Sends Gregorian dates with signed day offsets through the stream port and
// checks every result item against the directed table or its own date predictor.
// A short directed table covers the field extremes, nonexistent dates, the
// Julian calendar region, the range flag and the weekend roll. Random phases
// follow, switching weekend_roll between phases, with random idling on both
// sides and two long output stalls that back the pipeline up to its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import cadw_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int RAND_PHASES  = 8;
	localparam int PHASE_ITEMS  = 116;
	localparam int LONG_HOLD    = 300;

	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [DAY_W-1:0]   day;
		logic [WDAY_W-1:0]  wday;
		logic [DNUM_W-1:0]  dnum;
		logic               rerr;
	} date_res_t;

	typedef struct packed {
		logic                    roll;
		logic [YEAR_W-1:0]       year;
		logic [MONTH_W-1:0]      month;
		logic [DAY_W-1:0]        day;
		logic [OFFSET_WIDTH-1:0] offset;
		logic                    typed;
		date_res_t               want;
	} dir_row_t;

	localparam dir_row_t DIR_ROWS [24] = '{
		'{1'b0, 14'd2000, 4'd1, 5'd1, 21'h000000, 1'b1,
			'{14'd2000, 4'd1, 5'd1, 3'd6, 23'd2451545, 1'b0}},
		'{1'b0, 14'd1583, 4'd1, 5'd1, 21'h000000, 1'b1,
			'{14'd1583, 4'd1, 5'd1, 3'd6, 23'd2299239, 1'b0}},
		'{1'b0, 14'd1583, 4'd1, 5'd1, 21'h1FFFFF, 1'b1,
			'{14'd1582, 4'd12, 5'd31, 3'd5, 23'd2299238, 1'b1}},
		'{1'b0, 14'd9999, 4'd12, 5'd31, 21'h000000, 1'b1,
			'{14'd9999, 4'd12, 5'd31, 3'd5, 23'd5373484, 1'b0}},
		'{1'b0, 14'd9999, 4'd12, 5'd31, 21'h000001, 1'b1,
			'{14'd10000, 4'd1, 5'd1, 3'd6, 23'd5373485, 1'b1}},
		'{1'b0, 14'd2024, 4'd2, 5'd29, 21'h000000, 1'b0, '0},
		'{1'b0, 14'd1900, 4'd2, 5'd29, 21'h000000, 1'b0, '0},
		'{1'b0, 14'd2023, 4'd0, 5'd15, 21'h000064, 1'b0, '0},
		'{1'b0, 14'd2023, 4'd15, 5'd31, 21'h1FFF9C, 1'b0, '0},
		'{1'b0, 14'd2023, 4'd13, 5'd0, 21'h000000, 1'b0, '0},
		'{1'b0, 14'd0, 4'd1, 5'd1, 21'h000000, 1'b0, '0},
		'{1'b0, 14'd16383, 4'd15, 5'd31, 21'h0FFFFF, 1'b0, '0},
		'{1'b0, 14'd1583, 4'd1, 5'd1, 21'h100000, 1'b0, '0},
		'{1'b0, 14'd1582, 4'd10, 5'd15, 21'h1FFFFF, 1'b0, '0},
		'{1'b0, 14'd5000, 4'd6, 5'd15, 21'h100000, 1'b0, '0},
		'{1'b0, 14'd5000, 4'd6, 5'd15, 21'h0FFFFF, 1'b0, '0},
		'{1'b1, 14'd2000, 4'd1, 5'd1, 21'h000000, 1'b1,
			'{14'd2000, 4'd1, 5'd3, 3'd1, 23'd2451547, 1'b0}},
		'{1'b1, 14'd2000, 4'd1, 5'd2, 21'h000000, 1'b1,
			'{14'd2000, 4'd1, 5'd3, 3'd1, 23'd2451547, 1'b0}},
		'{1'b1, 14'd2000, 4'd1, 5'd3, 21'h000000, 1'b0, '0},
		'{1'b1, 14'd2000, 4'd1, 5'd1, 21'h1FFFFF, 1'b0, '0},
		'{1'b1, 14'd9999, 4'd12, 5'd31, 21'h000001, 1'b0, '0},
		'{1'b1, 14'd1582, 4'd10, 5'd15, 21'h1FFFFA, 1'b0, '0},
		'{1'b1, 14'd2024, 4'd3, 5'd30, 21'h000000, 1'b0, '0},
		'{1'b1, 14'd16383, 4'd15, 5'd31, 21'h0FFFFF, 1'b0, '0}
	};

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tuser;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic                   cfg_data = 1'b0;

	date_res_t due_dates [$];
	bit        roll_en = 1'b0;
	bit        tx_burst = 1'b0;
	int        mismatches = 0;
	int        cycles = 0;

	calendar_add_days_weekend_roll_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic longint floor_div(input longint n, input longint d);
		longint q;
		q = n / d;
		if ((n % d) != 0 && n < 0) begin
			q = q - 1;
		end
		return q;
	endfunction

	function automatic longint jdn_weekday(input longint jdn);
		return (jdn + 1) - 7 * floor_div(jdn + 1, 7);
	endfunction

	// Date to day number, add the offset, optional weekend roll, and back.
	function automatic date_res_t shift_date(input in_item_t it, input bit roll);
		longint    y, m, d, off, a, b, jdn, wd, x, c, dd, e, ry, rm, rd;
		date_res_t r;
		y   = longint'(it.in_year);
		m   = longint'(it.in_month);
		d   = longint'(it.in_day);
		off = $signed(it.day_offset);
		if (m <= 2) begin
			y = y - 1;
			m = m + 12;
		end
		a   = floor_div(y, 100);
		b   = 2 - a + floor_div(a, 4);
		jdn = floor_div(1461 * (y + 4716), 4) + floor_div(306001 * (m + 1), 10000)
			+ d + b - 1524 + off;
		wd  = jdn_weekday(jdn);
		if (roll) begin
			if (wd == 6) begin
				jdn = jdn + 2;
			end else if (wd == 0) begin
				jdn = jdn + 1;
			end
			wd = jdn_weekday(jdn);
		end
		if (jdn < GREG_JDN) begin
			a = jdn;
		end else begin
			x = floor_div(4 * jdn - 7468865, 146097);
			a = jdn + 1 + x - floor_div(x, 4);
		end
		b  = a + 1524;
		c  = floor_div(20 * b - 2442, 7305);
		dd = floor_div(1461 * c, 4);
		e  = floor_div(10000 * (b - dd), 306001);
		rd = b - dd - floor_div(306001 * e, 10000);
		rm = (e < 14) ? e - 1 : e - 13;
		ry = (rm > 2) ? c - 4716 : c - 4715;
		r.year  = ry[YEAR_W-1:0];
		r.month = rm[MONTH_W-1:0];
		r.day   = rd[DAY_W-1:0];
		r.wday  = wd[WDAY_W-1:0];
		r.dnum  = jdn[DNUM_W-1:0];
		r.rerr  = (ry < YEAR_MIN || ry > YEAR_MAX);
		return r;
	endfunction

	task automatic send_date(input in_item_t it, input bit typed, input date_res_t want);
		int gap;
		if ($urandom_range(0, 39) == 0) begin
			tx_burst = !tx_burst;
		end
		gap = tx_burst ? 0 : int'($urandom_range(0, 18));
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tdata  <= {{(IN_TDATA_W - IN_BITS){1'b0}}, it};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		due_dates.insert(due_dates.size(), typed ? want : shift_date(it, roll_en));
	endtask

	// The register is only written once every outstanding item has come back.
	task automatic set_roll(input bit v);
		s_axis_tvalid <= 1'b0;
		while (due_dates.size() != 0) @(posedge clk);
		cfg_data  <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		roll_en = v;
	endtask

	initial begin
		in_item_t    it;
		date_res_t   none;
		int unsigned r32;
		int          o;
		none = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		foreach (DIR_ROWS[i]) begin
			if (DIR_ROWS[i].roll != roll_en) begin
				set_roll(DIR_ROWS[i].roll);
			end
			it.in_year    = DIR_ROWS[i].year;
			it.in_month   = DIR_ROWS[i].month;
			it.in_day     = DIR_ROWS[i].day;
			it.day_offset = DIR_ROWS[i].offset;
			send_date(it, DIR_ROWS[i].typed, DIR_ROWS[i].want);
		end
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			set_roll(ph % 2 == 1);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				r32 = $urandom;
				if ($urandom_range(0, 9) < 7) begin
					it.in_year  = 14'($urandom_range(YEAR_MIN, YEAR_MAX));
					it.in_month = 4'($urandom_range(1, 12));
					it.in_day   = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(29, 31))
						: 5'($urandom_range(1, 28));
				end else begin
					it.in_year  = r32[13:0];
					it.in_month = r32[17:14];
					it.in_day   = r32[22:18];
				end
				case ($urandom_range(0, 3))
					0: begin
						o = int'($urandom_range(0, 800)) - 400;
					end
					1: begin
						o = int'($urandom_range(0, 120000)) - 60000;
					end
					default: begin
						r32 = $urandom;
						o = int'(r32);
					end
				endcase
				it.day_offset = 21'(o);
				send_date(it, 1'b0, none);
			end
		end
		s_axis_tvalid <= 1'b0;
		while (due_dates.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// The output side stalls at random and holds off twice for a long stretch.
	initial begin
		int taken;
		int stall;
		bit rx_burst;
		taken = 0;
		rx_burst = 1'b0;
		forever begin
			if ($urandom_range(0, 39) == 0) begin
				rx_burst = !rx_burst;
			end
			if (taken == 100 || taken == 500) begin
				stall = LONG_HOLD;
			end else begin
				stall = rx_burst ? 0 : int'($urandom_range(0, 18));
			end
			if (stall != 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			taken++;
		end
	end

	always @(posedge clk) begin : check_results
		out_data_t od;
		date_res_t got;
		date_res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			od = out_data_t'(m_axis_tdata[OUT_BITS-1:0]);
			got.year  = od.out_year;
			got.month = od.out_month;
			got.day   = od.out_day;
			got.wday  = od.out_weekday;
			got.dnum  = od.day_number;
			got.rerr  = m_axis_tuser;
			if (due_dates.size() == 0) begin
				if (mismatches < 10) begin
					$display("unexpected item: %0d-%0d-%0d wd %0d jdn %0d range %0d",
						got.year, got.month, got.day, got.wday, got.dnum, got.rerr);
				end
				mismatches++;
			end else begin
				want = due_dates.pop_front();
				if (got !== want) begin
					if (mismatches < 10) begin
						$display("mismatch: expected %0d-%0d-%0d wd %0d jdn %0d range %0d",
							want.year, want.month, want.day, want.wday, want.dnum,
							want.rerr);
						$display("          actual   %0d-%0d-%0d wd %0d jdn %0d range %0d",
							got.year, got.month, got.day, got.wday, got.dnum, got.rerr);
					end
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("Regression FAIL");
			$finish;
		end
	end

endmodule

// File: filelist.f
rtl/cadw_pkg.sv
rtl/cadw_fwd.sv
rtl/cadw_roll.sv
rtl/cadw_inv.sv
rtl/calendar_add_days_weekend_roll_core.sv
rtl/cadw_checker.sv
test/tb_top.sv
